>>> rtl/u16u8_pkg.sv
// shared types, constants and encode helper for the utf-16le to utf-8 transcoder
package u16u8_pkg;

	// most result bytes one code unit can cause: flushed high surrogate plus one unit
	localparam int MaxRes  = 6;
	localparam int ResCntW = $clog2(MaxRes + 1);

	// surrogate ranges by their top six bits
	localparam logic [5:0] HighSurrTag = 6'b110110;	// 0xd800..0xdbff
	localparam logic [5:0] LowSurrTag  = 6'b110111;	// 0xdc00..0xdfff

	// utf-8 length limits and byte marks
	localparam logic [15:0] OneByteLim = 16'h0080;
	localparam logic [15:0] TwoByteLim = 16'h0800;
	localparam logic [20:0] SuppBase   = 21'h10000;
	localparam logic [7:0]  Lead2Mark  = 8'hC0;
	localparam logic [7:0]  Lead3Mark  = 8'hE0;
	localparam logic [7:0]  Lead4Mark  = 8'hF0;
	localparam logic [7:0]  ContMark   = 8'h80;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       end_of_string;
	} res_t;

	// utf-8 bytes of a code point below 0x10000
	typedef struct packed {
		logic [2:0][7:0] b;
		logic [1:0]      len;
	} bmp_seq_t;

	function automatic bmp_seq_t enc_bmp(input logic [15:0] cp);
		bmp_seq_t s;
		s = '0;
		if (cp < OneByteLim) begin
			s.b[0] = cp[7:0];
			s.len  = 2'd1;
		end else if (cp < TwoByteLim) begin
			s.b[0] = Lead2Mark | {3'b000, cp[10:6]};
			s.b[1] = ContMark | {2'b00, cp[5:0]};
			s.len  = 2'd2;
		end else begin
			s.b[0] = Lead3Mark | {4'b0000, cp[15:12]};
			s.b[1] = ContMark | {2'b00, cp[11:6]};
			s.b[2] = ContMark | {2'b00, cp[5:0]};
			s.len  = 2'd3;
		end
		return s;
	endfunction

endpackage

>>> rtl/u16u8_if.sv
// handshake channel interfaces: code units in, utf-8 bytes out, mode register write

interface u16u8_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_unit;

	modport source (output valid, output code_unit, output last_unit, input ready);
	modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u16u8_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       end_of_string;

	modport source (output valid, output out_byte, output has_byte, output end_of_string,
		input ready);
	modport sink   (input valid, input out_byte, input has_byte, input end_of_string,
		output ready);
endinterface

interface u16u8_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/utf16le_to_utf8_transcoder.sv
// utf-16le / latin-1 to utf-8 transcoder top level
//
// units: code units of one string, last_unit marks the final unit of the bound.
// utf8:  one utf-8 byte per transfer; has_byte low marks an end-only item made
//        for a zero unit; end_of_string is set on the final item of the string.
// cfg:   always ready; data is narrow_input_mode (1 = latin-1 in code_unit[7:0]).
//        Write it only while the block is idle.
// A unit is registered in the input stage, decoded there in one pass into up to
// six result items, and loaded into a six-entry output shift buffer. The first
// byte is offered once the unit has passed the input stage register and been
// loaded into the output buffer. The buffer drains one byte per cycle while
// the receiver is ready; a unit yields up to six items (most yield one to three),
// and units yielding none do not load the buffer. The input stage takes a new unit
// while the buffer still drains its last byte.
// A receiver stall holds the buffer; the input stage then fills and units back
// up through units.ready. Reset clears the held surrogate, the terminator flag,
// the mode register and all valid state.
module utf16le_to_utf8_transcoder (
	input  logic               clk,
	input  logic               arst_n,
	u16u8_cfg_if.sink          cfg,
	u16u8_in_if.sink           units,
	u16u8_out_if.source        utf8
);

	// mode register
	logic narrow_q;

	// input stage
	logic        valid_s1;
	logic [15:0] unit_s1;
	logic        last_s1;

	// string state
	logic [9:0] held_payload_q;
	logic       held_valid_q;
	logic       after_term_q;

	// output buffer
	u16u8_pkg::res_t                          buf_s2 [u16u8_pkg::MaxRes];
	logic [u16u8_pkg::ResCntW-1:0]           cnt_s2;

	// decode results
	logic [15:0]                    unit_m;
	logic                           is_low, is_high, pair, flush, marker, hold_new;
	u16u8_pkg::bmp_seq_t            hs, us;
	logic [20:0]                    cp4;
	logic [3:0][7:0]                tail;
	logic [2:0]                     tail_len;
	logic [u16u8_pkg::ResCntW-1:0] n_res;
	logic [6:0][7:0]                lst;
	u16u8_pkg::res_t                res [u16u8_pkg::MaxRes];
	logic                           out_xfer, buf_free, adv;

	assign cfg.ready = 1'b1;

	// mode register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			narrow_q <= 1'b0;
		end else if (cfg.valid) begin
			narrow_q <= cfg.data;
		end
	end

	// unit classification
	always_comb begin
		unit_m   = narrow_q ? {8'h00, unit_s1[7:0]} : unit_s1;
		is_low   = !narrow_q && (unit_m[15:10] == u16u8_pkg::LowSurrTag);
		is_high  = !narrow_q && (unit_m[15:10] == u16u8_pkg::HighSurrTag);
		pair     = held_valid_q && is_low;
		flush    = held_valid_q && !pair;
		marker   = !pair && (unit_m == 16'h0000);
		hold_new = !pair && !marker && is_high && !last_s1;
		hs       = u16u8_pkg::enc_bmp({u16u8_pkg::HighSurrTag, held_payload_q});
		us       = u16u8_pkg::enc_bmp(unit_m);
		cp4      = u16u8_pkg::SuppBase + {1'b0, held_payload_q, unit_m[9:0]};
	end

	// bytes of the current unit
	always_comb begin
		tail = '0;
		if (pair) begin
			tail[0]  = u16u8_pkg::Lead4Mark | {5'b00000, cp4[20:18]};
			tail[1]  = u16u8_pkg::ContMark | {2'b00, cp4[17:12]};
			tail[2]  = u16u8_pkg::ContMark | {2'b00, cp4[11:6]};
			tail[3]  = u16u8_pkg::ContMark | {2'b00, cp4[5:0]};
			tail_len = 3'd4;
		end else if (marker) begin
			tail_len = 3'd1;
		end else if (hold_new) begin
			tail_len = 3'd0;
		end else begin
			tail[0]  = us.b[0];
			tail[1]  = us.b[1];
			tail[2]  = us.b[2];
			tail_len = {1'b0, us.len};
		end
	end

	// result list: flushed high surrogate first, then the current unit
	always_comb begin
		if (after_term_q) begin
			n_res = '0;
		end else begin
			n_res = (flush ? u16u8_pkg::ResCntW'(3) : '0) + u16u8_pkg::ResCntW'(tail_len);
		end
		if (flush) begin
			lst = {tail[3], tail[2], tail[1], tail[0], hs.b[2], hs.b[1], hs.b[0]};
		end else begin
			lst = {24'h000000, tail[3], tail[2], tail[1], tail[0]};
		end
		for (int i = 0; i < u16u8_pkg::MaxRes; i++) begin
			res[i].out_byte      = lst[i];
			res[i].has_byte      = !(marker && (u16u8_pkg::ResCntW'(i + 1) == n_res));
			res[i].end_of_string = (u16u8_pkg::ResCntW'(i + 1) == n_res) && (last_s1 || marker);
		end
	end

	// stage control
	assign out_xfer    = utf8.valid && utf8.ready;
	assign buf_free    = (cnt_s2 == '0) || ((cnt_s2 == u16u8_pkg::ResCntW'(1)) && utf8.ready);
	assign adv         = valid_s1 && ((n_res == '0) || buf_free);
	assign units.ready = !valid_s1 || adv;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (units.ready) begin
			valid_s1 <= units.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (units.ready && units.valid) begin
			unit_s1 <= units.code_unit;
			last_s1 <= units.last_unit;
		end
	end

	// string state update when the input stage retires its unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_payload_q <= '0;
			held_valid_q   <= 1'b0;
			after_term_q   <= 1'b0;
		end else if (adv) begin
			if (after_term_q) begin
				after_term_q <= !last_s1;
			end else begin
				after_term_q   <= marker && !last_s1;
				held_valid_q   <= hold_new;
				held_payload_q <= hold_new ? unit_m[9:0] : '0;
			end
		end
	end

	// output buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (adv && (n_res != '0)) begin
			cnt_s2 <= n_res;
		end else if (out_xfer) begin
			cnt_s2 <= cnt_s2 - u16u8_pkg::ResCntW'(1);
		end
	end

	// output buffer entries: load a whole list or shift one out
	always_ff @(posedge clk) begin
		if (adv && (n_res != '0)) begin
			for (int i = 0; i < u16u8_pkg::MaxRes; i++) begin
				buf_s2[i] <= res[i];
			end
		end else if (out_xfer) begin
			for (int i = 0; i < u16u8_pkg::MaxRes - 1; i++) begin
				buf_s2[i] <= buf_s2[i + 1];
			end
		end
	end

	assign utf8.valid         = (cnt_s2 != '0);
	assign utf8.out_byte      = buf_s2[0].out_byte;
	assign utf8.has_byte      = buf_s2[0].has_byte;
	assign utf8.end_of_string = buf_s2[0].end_of_string;

endmodule

>>> rtl/u16u8_checker.sv
// port-level checks on the transcoder output channel
module u16u8_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       has_byte,
	input logic       end_of_string
);

	logic lead_byte;

	assign lead_byte = has_byte && (out_byte[7:6] == 2'b11);

	// stalled item holds its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(out_byte) && $stable(has_byte) && $stable(end_of_string))
		else $error("output payload changed during stall");

	// an end-only item carries a zero byte and closes the string
	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> end_of_string && (out_byte == 8'h00))
		else $error("malformed end-only item");

	// a lead byte never closes the string
	a_lead_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lead_byte |-> !end_of_string)
		else $error("lead byte marked as end of string");

	// continuation bytes follow a lead byte without a gap
	a_lead_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && lead_byte |=> out_valid && (out_byte[7:6] == 2'b10))
		else $error("lead byte not followed by a continuation byte");

endmodule

bind utf16le_to_utf8_transcoder u16u8_checker u_u16u8_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (utf8.valid),
	.out_ready     (utf8.ready),
	.out_byte      (utf8.out_byte),
	.has_byte      (utf8.has_byte),
	.end_of_string (utf8.end_of_string)
);

>>> tb/testbench.sv
// self-checking testbench for the utf-16le / latin-1 to utf-8 transcoder
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 16;
	localparam int MaxPrinted  = 40;

	logic clk = 1'b0;
	logic arst_n;

	u16u8_cfg_if cfg_bus ();
	u16u8_in_if  unit_bus ();
	u16u8_out_if byte_bus ();

	utf16le_to_utf8_transcoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.units  (unit_bus),
		.utf8   (byte_bus)
	);

	// transcoder state mirror
	logic       narrow_mode;
	logic [9:0] held_payload;
	logic       held_valid;
	logic       after_term;

	u16u8_pkg::res_t utf8_expected[$];

	int err_count     = 0;
	int cycle_count   = 0;
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;

	// clock
	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
				utf8_expected.size());
			$display("utf16le_to_utf8_transcoder test failed");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		byte_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic report_mismatch(input string msg);
		if (err_count < MaxPrinted)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		err_count++;
	endtask

	// expected result queue
	task automatic push_byte(input logic [7:0] b, input logic has, input logic eos);
		u16u8_pkg::res_t r;
		r.out_byte      = b;
		r.has_byte      = has;
		r.end_of_string = eos;
		utf8_expected = {utf8_expected, r};
	endtask

	// utf-8 encoding of one code point
	task automatic push_code_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			push_byte(cp[7:0], 1'b1, 1'b0);
		end else if (cp < 21'h800) begin
			push_byte(8'hC0 | {3'b000, cp[10:6]}, 1'b1, 1'b0);
			push_byte(8'h80 | {2'b00, cp[5:0]}, 1'b1, 1'b0);
		end else if (cp < 21'h10000) begin
			push_byte(8'hE0 | {4'b0000, cp[15:12]}, 1'b1, 1'b0);
			push_byte(8'h80 | {2'b00, cp[11:6]}, 1'b1, 1'b0);
			push_byte(8'h80 | {2'b00, cp[5:0]}, 1'b1, 1'b0);
		end else begin
			push_byte(8'hF0 | {5'b00000, cp[20:18]}, 1'b1, 1'b0);
			push_byte(8'h80 | {2'b00, cp[17:12]}, 1'b1, 1'b0);
			push_byte(8'h80 | {2'b00, cp[11:6]}, 1'b1, 1'b0);
			push_byte(8'h80 | {2'b00, cp[5:0]}, 1'b1, 1'b0);
		end
	endtask

	// expected bytes for one accepted code unit
	task automatic predict_utf8(input logic [15:0] cu, input logic last);
		logic [15:0] u;
		logic [15:0] high;
		int          start;
		start = utf8_expected.size();
		// units after a terminator are dropped up to the bound
		if (after_term) begin
			if (last)
				after_term = 1'b0;
			return;
		end
		u = cu;
		if (narrow_mode)
			u[15:8] = 8'h00;
		// pending high surrogate: join with a low one or flush it alone
		if (held_valid) begin
			high         = {u16u8_pkg::HighSurrTag, held_payload};
			held_valid   = 1'b0;
			held_payload = '0;
			if (!narrow_mode && u[15:10] == u16u8_pkg::LowSurrTag) begin
				push_code_point(21'h10000 + {1'b0, high[9:0], u[9:0]});
				if (last)
					utf8_expected[utf8_expected.size() - 1].end_of_string = 1'b1;
				return;
			end
			push_code_point({5'b00000, high});
		end
		// zero unit ends the string with a marker
		if (u == 16'h0000) begin
			push_byte(8'h00, 1'b0, 1'b1);
			if (!last)
				after_term = 1'b1;
			return;
		end
		// high surrogate waits for its partner unless the bound ends here
		if (!narrow_mode && u[15:10] == u16u8_pkg::HighSurrTag && !last) begin
			held_payload = u[9:0];
			held_valid   = 1'b1;
			return;
		end
		push_code_point({5'b00000, u});
		if (last && utf8_expected.size() > start)
			utf8_expected[utf8_expected.size() - 1].end_of_string = 1'b1;
	endtask

	// output checker
	always @(posedge clk) begin
		u16u8_pkg::res_t want;
		if (arst_n && byte_bus.valid && byte_bus.ready) begin
			if (utf8_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h has %b end %b",
					byte_bus.out_byte, byte_bus.has_byte, byte_bus.end_of_string));
			end else begin
				want = utf8_expected.pop_front();
				if (byte_bus.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %02h, expected %02h",
						byte_bus.out_byte, want.out_byte));
				if (byte_bus.has_byte !== want.has_byte)
					report_mismatch($sformatf("has_byte %b, expected %b",
						byte_bus.has_byte, want.has_byte));
				if (byte_bus.end_of_string !== want.end_of_string)
					report_mismatch($sformatf("end_of_string %b, expected %b",
						byte_bus.end_of_string, want.end_of_string));
			end
		end
	end

	// one code unit transfer, with random sender gaps
	task automatic send_unit(input logic [15:0] cu, input logic last);
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			unit_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		unit_bus.valid     <= 1'b1;
		unit_bus.code_unit <= cu;
		unit_bus.last_unit <= last;
		do @(posedge clk); while (!unit_bus.ready);
		predict_utf8(cu, last);
	endtask

	// let all expected bytes arrive and the pipeline settle
	task automatic wait_drained();
		unit_bus.valid <= 1'b0;
		while (utf8_expected.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_mode(input logic narrow);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= narrow;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		narrow_mode = narrow;
	endtask

	// random unit weighted toward each utf-8 length and surrogates
	function automatic logic [15:0] pick_unit();
		int sel;
		sel = $urandom_range(99);
		if (sel < 25) return 16'($urandom_range(16'h007F, 16'h0001));
		if (sel < 40) return 16'($urandom_range(16'h07FF, 16'h0080));
		if (sel < 55) return 16'($urandom_range(16'hD7FF, 16'h0800));
		if (sel < 65) return 16'($urandom_range(16'hFFFF, 16'hE000));
		if (sel < 72) return 16'($urandom_range(16'hDBFF, 16'hD800));
		if (sel < 79) return 16'($urandom_range(16'hDFFF, 16'hDC00));
		return 16'($urandom);
	endfunction

	// utf-8 length extremes, pairs, lone surrogates and terminators
	task automatic test_wide_directed();
		wait_drained();
		write_mode(1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		// lowest and highest surrogate pairs
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDFFF, 1'b0);
		// lone low, then high flushed by a plain unit and by another high
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hD801, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hDA00, 1'b0);
		send_unit(16'hDB00, 1'b0);
		send_unit(16'hDC55, 1'b0);
		// high surrogate on the bound
		send_unit(16'hD83D, 1'b1);
		// held high flushed by a terminator, then dropped units up to the bound
		send_unit(16'hD800, 1'b0);
		send_unit(16'h0000, 1'b0);
		send_unit(16'h1234, 1'b0);
		send_unit(16'h0000, 1'b1);
		// terminator on the bound
		send_unit(16'h0000, 1'b1);
	endtask

	// held high surrogate flushed by a latin-1 unit after a mode change
	task automatic test_held_across_mode();
		send_unit(16'hD812, 1'b0);
		wait_drained();
		write_mode(1'b1);
		send_unit(16'h41FF, 1'b1);
	endtask

	// latin-1 bytes with junk upper bits and a terminator from the low byte
	task automatic test_narrow_directed();
		send_unit(16'hFF80, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'hD800, 1'b0);
		send_unit(16'hAB41, 1'b1);
	endtask

	// random strings, mostly well-formed, each ended by the bound
	task automatic test_random_strings(input logic narrow, input int src_pct,
		input int sink_pct, input int unit_total);
		int          sent;
		int          len;
		int          i;
		logic [15:0] cu;
		wait_drained();
		write_mode(narrow);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		sent = 0;
		while (sent < unit_total) begin
			len = $urandom_range(8, 1);
			i   = 0;
			while (i < len) begin
				if (i + 1 < len && $urandom_range(99) < 25) begin
					send_unit(16'hD800 | 16'($urandom_range(16'h03FF)), 1'b0);
					send_unit(16'hDC00 | 16'($urandom_range(16'h03FF)), i + 2 == len);
					i += 2;
				end else begin
					cu = ($urandom_range(99) < 5) ? 16'h0000 : pick_unit();
					send_unit(cu, i + 1 == len);
					i++;
				end
			end
			sent += len;
		end
	endtask

	// test sequence
	initial begin
		arst_n             = 1'b0;
		unit_bus.valid     = 1'b0;
		unit_bus.code_unit = '0;
		unit_bus.last_unit = 1'b0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.data       = 1'b0;
		byte_bus.ready     = 1'b0;
		narrow_mode        = 1'b0;
		held_payload       = '0;
		held_valid         = 1'b0;
		after_term         = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_wide_directed();
		test_held_across_mode();
		test_narrow_directed();
		test_random_strings(1'b0, 37, 57, 24);
		test_random_strings(1'b1, 57, 37, 24);
		test_random_strings(1'b0, 0, 0, 24);
		wait_drained();

		if (err_count == 0)
			$display("utf16le_to_utf8_transcoder test passed");
		else
			$display("utf16le_to_utf8_transcoder test failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/u16u8_pkg.sv
rtl/u16u8_if.sv
rtl/utf16le_to_utf8_transcoder.sv
rtl/u16u8_checker.sv
tb/testbench.sv
